/* design/longest_zero_run_four_directions_assert.svh */
// Assertion macros shared by the longest zero run design files.
`ifndef LONGEST_ZERO_RUN_FOUR_DIRECTIONS_ASSERT_SVH
`define LONGEST_ZERO_RUN_FOUR_DIRECTIONS_ASSERT_SVH

`ifndef ASSERT_OFF
// Check a condition at every clock edge outside reset.
`define LZR_ASSERT(label, cond) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error("lzr assertion failed");
// Check that a condition in one cycle leads to another in the next cycle.
`define LZR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("lzr assertion failed");
`else
`define LZR_ASSERT(label, cond)
`define LZR_ASSERT_NEXT(label, ante, cons)
`endif

`endif

/* design/lzr_pkg.sv */
package lzr_pkg;

    // Configuration port
    localparam int CFG_W      = 7;
    localparam int CFG_IDX_W  = 1;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_COLUMNS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS    = 1'b1;
    localparam int CFG_RESET  = 64;

    // Stream payloads
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 8;
    localparam int RESULT_W   = 7;
    localparam int RESULT_MAX = 127;

    // Position flags handed from the frame tracker to the datapath
    typedef struct packed {
        logic first_row;
        logic first_col;
        logic last_col;
        logic last_pixel;
    } lzr_pos_t;

endpackage

/* design/lzr_cell.sv */
module lzr_cell #(
    parameter int DW = 21
) (
    input  logic          aclk,
    input  logic          shift_en,
    input  logic          load_sel,
    input  logic [DW-1:0] new_data,
    input  logic [DW-1:0] neighbor_data,
    output logic [DW-1:0] data_q
);

    logic [DW-1:0] data_reg;
    logic [DW-1:0] data_next;

    // Take the fresh entry at the row's end, otherwise the right neighbor's
    always_comb begin
        data_next = load_sel ? new_data : neighbor_data;
    end

    // Advance one place per accepted item
    always_ff @(posedge aclk) begin
        if (shift_en) begin
            data_reg <= data_next;
        end
    end

    assign data_q = data_reg;

endmodule

/* design/lzr_ctrl.sv */
module lzr_ctrl #(
    parameter int MAX_COLUMNS = 64,
    parameter int MAX_ROWS    = 64,
    parameter int CW          = 7
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [lzr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lzr_pkg::CFG_W-1:0]       cfg_data,
    input  logic                            step,
    output logic                            restart,
    output logic [CW-1:0]                   num_columns,
    output lzr_pkg::lzr_pos_t               pos
);
    import lzr_pkg::*;

    localparam int PW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int RCW = $clog2(MAX_ROWS + 1);
    localparam int COLS_RESET = (CFG_RESET > MAX_COLUMNS) ? MAX_COLUMNS : CFG_RESET;
    localparam int ROWS_RESET = (CFG_RESET > MAX_ROWS) ? MAX_ROWS : CFG_RESET;

    logic [CW-1:0]  cols_reg, cols_next;
    logic [RCW-1:0] rows_reg, rows_next;
    logic [PW-1:0]  col_reg, col_next;
    logic [RW-1:0]  row_reg, row_next;
    logic           last_row;

    // Clamp register writes into the supported range; any write restarts the frame
    always_comb begin
        int unsigned v;
        int unsigned vc;
        int unsigned vr;
        v  = 32'(cfg_data);
        vc = (v == 0) ? 1 : ((v > MAX_COLUMNS) ? MAX_COLUMNS : v);
        vr = (v == 0) ? 1 : ((v > MAX_ROWS) ? MAX_ROWS : v);
        cols_next = cols_reg;
        rows_next = rows_reg;
        restart   = 1'b0;
        if (cfg_we) begin
            case (cfg_index)
                REG_NUM_COLUMNS: begin
                    cols_next = CW'(vc);
                    restart   = 1'b1;
                end
                REG_NUM_ROWS: begin
                    rows_next = RCW'(vr);
                    restart   = 1'b1;
                end
                default: begin
                    restart = 1'b0;
                end
            endcase
        end
    end

    // Position flags for the current item
    always_comb begin
        pos.first_row  = (row_reg == '0);
        pos.first_col  = (col_reg == '0);
        pos.last_col   = ((CW'(col_reg) + CW'(1)) == cols_reg);
        last_row       = ((RCW'(row_reg) + RCW'(1)) == rows_reg);
        pos.last_pixel = pos.last_col && last_row;
    end

    // Advance the raster position
    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (restart) begin
            col_next = '0;
            row_next = '0;
        end else if (step) begin
            if (!pos.last_col) begin
                col_next = col_reg + PW'(1);
            end else if (!last_row) begin
                col_next = '0;
                row_next = row_reg + RW'(1);
            end else begin
                col_next = '0;
                row_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cols_reg <= CW'(COLS_RESET);
            rows_reg <= RCW'(ROWS_RESET);
            col_reg  <= '0;
            row_reg  <= '0;
        end else begin
            cols_reg <= cols_next;
            rows_reg <= rows_next;
            col_reg  <= col_next;
            row_reg  <= row_next;
        end
    end

    assign num_columns = cols_reg;

`include "longest_zero_run_four_directions_assert.svh"

    `LZR_ASSERT(a_col_in_range, (32'(col_reg) < 32'(cols_reg)))
    `LZR_ASSERT(a_row_in_range, (32'(row_reg) < 32'(rows_reg)))
    `LZR_ASSERT_NEXT(a_frame_wraps, (step && !restart && pos.last_pixel), (col_reg == '0 && row_reg == '0))

endmodule

/* design/longest_zero_run_four_directions.sv */
// Longest zero run, four directions.
// Pixels of a binary image enter on the s_axis channel in raster order, one item
// per pixel, row by row and left to right; bit 0 of s_axis_tdata is the pixel and a
// zero extends runs. The block tracks zero runs along rows, columns and both
// diagonals. On the frame's last pixel it places one result on m_axis: the longest
// run (at least 1) and a flag that is set when no run is longer than one.
// num_columns and num_rows are to be written through cfg_we/cfg_index/cfg_data only
// while the block is idle, which the block itself does not enforce; each write restarts
// the frame. Zero acts as 1 and values above the maximum act as the maximum.
// Throughput: one pixel per cycle while s_axis_tready is high; the previous-row runs
// travel through a chain of per-column cells that advances once per accepted pixel,
// so the row-end insert and head read both happen as each pixel is accepted.
// Latency: the result is valid the cycle after the last pixel is accepted.
// A result waits in the output register while m_axis_tready is low; pixels keep
// flowing until another result is due, and s_axis_tready drops only while a
// result is held and the receiver stalls.
// Reset restores both registers to 64 (clamped to the maximum) and starts a frame.
module longest_zero_run_four_directions #(
    parameter int MAX_COLUMNS = 64,
    parameter int MAX_ROWS    = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration write port
    input  logic                          cfg_we,
    input  logic [lzr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lzr_pkg::CFG_W-1:0]     cfg_data,
    // pixel input
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [lzr_pkg::S_TDATA_W-1:0] s_axis_tdata,  // [0] pixel, [7:1] zero
    // result output
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [lzr_pkg::M_TDATA_W-1:0] m_axis_tdata   // [6:0] longest_run, [7] no_chain
);
    import lzr_pkg::*;

    localparam int MAX_DIM = (MAX_COLUMNS > MAX_ROWS) ? MAX_COLUMNS : MAX_ROWS;
    localparam int RUN_W   = $clog2(MAX_DIM + 1);
    localparam int DW      = 3 * RUN_W;
    localparam int CW      = $clog2(MAX_COLUMNS + 1);

    logic           in_fire;
    logic           restart;
    logic [CW-1:0]  num_columns;
    lzr_pos_t       pos;

    logic [DW-1:0]  cell_q [MAX_COLUMNS];
    logic [DW-1:0]  new_entry;

    logic [RUN_W-1:0] row_run_reg, row_run_next;
    logic [RUN_W-1:0] diag_hold_reg, diag_hold_next;
    logic [RUN_W-1:0] best_run_reg, best_run_next;
    logic [RUN_W-1:0] run_h, run_v, run_dr, run_dl, run_ul, run_ur, best_all;
    logic             zero;

    logic                  m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0]  m_data_reg, m_data_next;
    logic [RESULT_W-1:0]   longest;

    // Hold the input only when a frame's last pixel meets a waiting, stalled result
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = !m_valid_reg || m_axis_tready || !pos.last_pixel;

    lzr_ctrl #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS),
        .CW          (CW)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .step        (in_fire),
        .restart     (restart),
        .num_columns (num_columns),
        .pos         (pos)
    );

    // Column chain: cell 0 holds the previous row's runs at the current column
    for (genvar k = 0; k < MAX_COLUMNS; k++) begin : g_cell
        logic [DW-1:0] neighbor;
        if (k == MAX_COLUMNS - 1) begin : g_tail
            assign neighbor = '0;
        end else begin : g_body
            assign neighbor = cell_q[k+1];
        end
        lzr_cell #(
            .DW (DW)
        ) u_cell (
            .aclk          (aclk),
            .shift_en      (in_fire),
            .load_sel      (num_columns == CW'(k + 1)),
            .new_data      (new_entry),
            .neighbor_data (neighbor),
            .data_q        (cell_q[k])
        );
    end

    // Runs ending at the current pixel; missing neighbors count as zero
    always_comb begin
        zero   = !s_axis_tdata[0];
        run_h  = zero ? ((pos.first_col ? '0 : row_run_reg) + RUN_W'(1)) : '0;
        run_v  = zero ? ((pos.first_row ? '0 : cell_q[0][RUN_W-1:0]) + RUN_W'(1)) : '0;
        run_ul = (!pos.first_row && !pos.first_col) ? diag_hold_reg : '0;
        run_dr = zero ? (run_ul + RUN_W'(1)) : '0;
        run_ur = (!pos.first_row && !pos.last_col) ? cell_q[1][3*RUN_W-1:2*RUN_W] : '0;
        run_dl = zero ? (run_ur + RUN_W'(1)) : '0;
        new_entry = {run_dl, run_dr, run_v};
    end

    // Fold the four runs into the frame's best
    always_comb begin
        best_all = best_run_reg;
        if (run_h > best_all) best_all = run_h;
        if (run_v > best_all) best_all = run_v;
        if (run_dr > best_all) best_all = run_dr;
        if (run_dl > best_all) best_all = run_dl;
        longest = (32'(best_all) > RESULT_MAX) ? RESULT_W'(RESULT_MAX) : RESULT_W'(best_all);
    end

    // Update frame state and the output register
    always_comb begin
        row_run_next   = row_run_reg;
        diag_hold_next = diag_hold_reg;
        best_run_next  = best_run_reg;
        m_valid_next   = m_valid_reg && !m_axis_tready;
        m_data_next    = m_data_reg;
        if (restart) begin
            row_run_next   = '0;
            diag_hold_next = '0;
            best_run_next  = RUN_W'(1);
        end else if (in_fire) begin
            row_run_next   = run_h;
            diag_hold_next = cell_q[0][2*RUN_W-1:RUN_W];
            best_run_next  = best_all;
            if (pos.last_pixel) begin
                best_run_next  = RUN_W'(1);
                row_run_next   = '0;
                diag_hold_next = '0;
                m_valid_next   = 1'b1;
                m_data_next    = {(best_all == RUN_W'(1)), longest};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_run_reg   <= '0;
            diag_hold_reg <= '0;
            best_run_reg  <= RUN_W'(1);
            m_valid_reg   <= 1'b0;
        end else begin
            row_run_reg   <= row_run_next;
            diag_hold_reg <= diag_hold_next;
            best_run_reg  <= best_run_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Payload holds no reset
    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

`include "longest_zero_run_four_directions_assert.svh"

    `LZR_ASSERT(a_best_nonzero, (best_run_reg != '0))
    `LZR_ASSERT(a_stall_only_on_result, (!s_axis_tready |-> m_axis_tvalid))
    `LZR_ASSERT_NEXT(a_result_follows_frame, (in_fire && pos.last_pixel && !restart), m_axis_tvalid)
    `LZR_ASSERT(a_flag_matches_run, (m_axis_tvalid |-> (m_axis_tdata[7] == (m_axis_tdata[6:0] == 7'd1))))

endmodule

/* bench/tb_longest_zero_run_four_directions.sv */
module tb_longest_zero_run_four_directions;
    import lzr_pkg::*;

    localparam int MAX_DIM      = 64;
    localparam int PIXEL_BUDGET = 1050;
    localparam int IDLE_LIMIT   = 4000;
    localparam int LONG_HOLD    = 300;

    // one frame result as it leaves on m_axis
    typedef struct packed {
        logic [RESULT_W-1:0] run;
        logic                no_chain;
    } run_result_t;

    // directed frame: sizes as written to the registers, pixels in raster order
    typedef struct packed {
        logic [CFG_W-1:0]    cols_raw;
        logic [CFG_W-1:0]    rows_raw;
        logic [7:0]          pixels;
        logic                known;
        logic [RESULT_W-1:0] run;
        logic                no_chain;
    } frame_case_t;

    logic                 aclk          = 1'b0;
    logic                 aresetn       = 1'b0;
    logic                 cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index     = '0;
    logic [CFG_W-1:0]     cfg_data      = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;  // [0] pixel, [7:1] zero
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;        // [6:0] longest_run, [7] no_chain

    // frames: lone zero, all ones with zero sizes, down-right and down-left
    // diagonals, zero row count, a column run, then a mixed frame
    frame_case_t directed_frames [7] = '{
        '{7'd1, 7'd1, 8'h00, 1'b1, 7'd1, 1'b1},
        '{7'd0, 7'd0, 8'h01, 1'b1, 7'd1, 1'b1},
        '{7'd2, 7'd2, 8'h06, 1'b1, 7'd2, 1'b0},
        '{7'd2, 7'd2, 8'h09, 1'b1, 7'd2, 1'b0},
        '{7'd3, 7'd0, 8'h02, 1'b1, 7'd1, 1'b1},
        '{7'd2, 7'd3, 8'h15, 1'b1, 7'd3, 1'b0},
        '{7'd3, 7'd2, 8'h29, 1'b0, 7'd0, 1'b0}
    };

    // run tracker state
    logic [6:0] cols_eff = 7'd64;
    logic [6:0] rows_eff = 7'd64;
    logic [6:0] pos_col  = '0;
    logic [6:0] pos_row  = '0;
    logic [6:0] row_run  = '0;
    logic [6:0] diag_hold = '0;
    logic [6:0] best_run = 7'd1;
    logic [6:0] col_run_mem [MAX_DIM] = '{default: '0};
    logic [6:0] dr_run_mem  [MAX_DIM] = '{default: '0};
    logic [6:0] dl_run_mem  [MAX_DIM] = '{default: '0};

    run_result_t         expected_runs [$];
    logic                known_armed = 1'b0;
    run_result_t         known_result;
    int                  error_count = 0;
    int                  idle_cycles = 0;
    logic                hold_request = 1'b0;

    longest_zero_run_four_directions i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic logic [6:0] clamp_dim(input logic [CFG_W-1:0] raw);
        if (raw == 0) return 7'd1;
        if (raw > MAX_DIM) return 7'(MAX_DIM);
        return raw;
    endfunction

    function automatic void restart_frame();
        row_run   = '0;
        diag_hold = '0;
        best_run  = 7'd1;
        pos_col   = '0;
        pos_row   = '0;
    endfunction

    // Advance the run tracker by one pixel; return 1 when the frame closes.
    function automatic logic track_pixel(input logic pix, output run_result_t res);
        logic       zero;
        logic [6:0] c, r, h, v, ul, ur, dr, dl;
        zero = !pix;
        c    = pos_col;
        r    = pos_row;
        res  = '0;

        h  = zero ? ((c != 0) ? row_run : 7'd0) + 7'd1 : 7'd0;
        v  = zero ? ((r != 0) ? col_run_mem[c] : 7'd0) + 7'd1 : 7'd0;
        // the down-right entry of this column is replaced below, so keep it for c+1
        ul = (r != 0 && c != 0) ? diag_hold : 7'd0;
        diag_hold = dr_run_mem[c];
        dr = zero ? ul + 7'd1 : 7'd0;
        ur = (r != 0 && c + 7'd1 < cols_eff) ? dl_run_mem[c + 7'd1] : 7'd0;
        dl = zero ? ur + 7'd1 : 7'd0;

        row_run        = h;
        col_run_mem[c] = v;
        dr_run_mem[c]  = dr;
        dl_run_mem[c]  = dl;
        if (h > best_run) best_run = h;
        if (v > best_run) best_run = v;
        if (dr > best_run) best_run = dr;
        if (dl > best_run) best_run = dl;

        if (c + 7'd1 < cols_eff) begin
            pos_col = c + 7'd1;
            return 1'b0;
        end
        if (r + 7'd1 < rows_eff) begin
            pos_col = '0;
            pos_row = r + 7'd1;
            return 1'b0;
        end
        res.run      = best_run;
        res.no_chain = (best_run == 7'd1);
        restart_frame();
        return 1'b1;
    endfunction

    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 65) return 0;
        if (roll < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic int pick_one_pct();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return 10;
            2: return 30;
            3: return 50;
            4: return 90;
            default: return 100;
        endcase
    endfunction

    // Offer one pixel and hold it until accepted.
    task automatic send_pixel(input logic pix);
        int gap;
        s_axis_tdata  <= {{(S_TDATA_W-1){1'b0}}, pix};
        s_axis_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Drop valid and wait until every frame result has come back.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_runs.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Write both size registers on consecutive edges; each write restarts the frame.
    task automatic set_frame_size(input logic [CFG_W-1:0] cols_raw,
                                  input logic [CFG_W-1:0] rows_raw);
        cfg_we    <= 1'b1;
        cfg_index <= REG_NUM_COLUMNS;
        cfg_data  <= cols_raw;
        @(posedge aclk);
        cfg_index <= REG_NUM_ROWS;
        cfg_data  <= rows_raw;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        cols_eff = clamp_dim(cols_raw);
        rows_eff = clamp_dim(rows_raw);
        restart_frame();
    endtask

    // stimulus: directed frames, then random frames in phases of one size
    initial begin : stimulus
        int          sent;
        int          frames;
        int          one_pct;
        int          npix;
        logic [6:0]  c_raw, r_raw;
        logic        pressure_done;
        sent = 0;
        pressure_done = 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_frames[i]) begin
            wait_drained();
            set_frame_size(directed_frames[i].cols_raw, directed_frames[i].rows_raw);
            known_armed           = directed_frames[i].known;
            known_result.run      = directed_frames[i].run;
            known_result.no_chain = directed_frames[i].no_chain;
            npix = int'(cols_eff) * int'(rows_eff);
            for (int k = 0; k < npix; k++) begin
                send_pixel(directed_frames[i].pixels[k]);
                sent++;
            end
        end

        while (sent < PIXEL_BUDGET) begin
            wait_drained();
            frames = $urandom_range(1, 5);
            if (!pressure_done && sent > 300) begin
                // many tiny frames while the receiver holds off
                c_raw = 7'd2;
                r_raw = 7'd2;
                frames = 40;
                pressure_done = 1'b1;
                hold_request = 1'b1;
            end else begin
                case ($urandom_range(0, 19))
                    0: begin
                        c_raw = $urandom_range(0, 1) ? 7'd64 : 7'($urandom_range(65, 127));
                        r_raw = 7'($urandom_range(0, 2));
                        frames = 1;
                    end
                    1: begin
                        c_raw = 7'($urandom_range(0, 1));
                        r_raw = $urandom_range(0, 1) ? 7'd64 : 7'($urandom_range(65, 127));
                        frames = 1;
                    end
                    2: begin
                        c_raw = 7'd0;
                        r_raw = 7'd0;
                    end
                    default: begin
                        c_raw = 7'($urandom_range(1, 8));
                        r_raw = 7'($urandom_range(1, 8));
                    end
                endcase
            end
            set_frame_size(c_raw, r_raw);
            npix = int'(cols_eff) * int'(rows_eff);
            // stop at a frame boundary once the budget is spent
            repeat (frames) begin
                if (sent >= PIXEL_BUDGET) break;
                one_pct = pick_one_pct();
                for (int k = 0; k < npix; k++) begin
                    send_pixel($urandom_range(0, 99) < one_pct);
                    sent++;
                end
            end
        end

        wait_drained();
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // receiver: random stalls, ready stretches, one long hold on request
    initial begin : receiver
        int stall;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                stall = LONG_HOLD;
            end else begin
                stall = pick_gap();
            end
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge aclk);
        end
    end

    // predict on each accepted pixel, compare each accepted result
    always @(posedge aclk) begin : scoreboard
        run_result_t res;
        run_result_t got;
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready) begin
                if (track_pixel(s_axis_tdata[0], res)) begin
                    if (known_armed) begin
                        res = known_result;
                        known_armed = 1'b0;
                    end
                    expected_runs.push_back(res);
                end
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.run      = m_axis_tdata[RESULT_W-1:0];
                got.no_chain = m_axis_tdata[RESULT_W];
                if (expected_runs.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got run %0d no_chain %0b",
                             $realtime, got.run, got.no_chain);
                    error_count++;
                end else begin
                    res = expected_runs.pop_front();
                    if (got.run !== res.run) begin
                        $display("%0t: longest_run mismatch, expected %0d, got %0d",
                                 $realtime, res.run, got.run);
                        error_count++;
                    end
                    if (got.no_chain !== res.no_chain) begin
                        $display("%0t: no_chain mismatch, expected %0b, got %0b",
                                 $realtime, res.no_chain, got.no_chain);
                        error_count++;
                    end
                end
            end
        end
    end

    // end the run when nothing moves for too long
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

endmodule
